// ===== rtl/core/fcg_pkg.sv =====
package fcg_pkg;

    // Widths of the configuration port and of the item fields.
    localparam int CFG_DIM_W  = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int PIXEL_W    = 16;
    localparam int COORD_W    = 20;
    localparam int OFFSET_W   = 21;
    localparam int STATUS_W   = 2;

    localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};

    // Defaults for the top level parameters.
    localparam int MAX_DIM_DEF    = 4096;
    localparam int PIXEL_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    // Frames narrower or shorter than this get no centroid.
    localparam int MIN_DIM = 3;

    // Reset values of the configuration registers.
    localparam logic [CFG_DIM_W-1:0] WIDTH_RST  = CFG_DIM_W'(640);
    localparam logic [CFG_DIM_W-1:0] HEIGHT_RST = CFG_DIM_W'(480);

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_REF_X        = 2'd2,
        REG_REF_Y        = 2'd3
    } cfg_reg_t;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SMALL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ZERO  = 2'd2;

    // Occupancy report of the frame queue.
    typedef struct packed {
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_status_t;

endpackage

// ===== rtl/core/frame_centroid_guide_offset.sv =====
// Intensity-weighted frame centroid with guide offsets.
// Pixels are taken at one per cycle while in_stall is low; a result follows the
// last pixel of a frame through the one-bit-per-cycle divider in the back end,
// which holds one frame at a time. Frames that come faster than the divider
// drains them fill the two-entry frame queue and then stall input.
// Reset (rst_n low, asynchronous) clears sums, positions and queue, and loads
// frame size 640 by 480 and reference 0, 0.
module frame_centroid_guide_offset
    import fcg_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [PIXEL_W-1:0]         pixel,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [COORD_W-1:0]         center_x,
    output logic [COORD_W-1:0]         center_y,
    output logic signed [OFFSET_W-1:0] offset_x,
    output logic signed [OFFSET_W-1:0] offset_y,
    output logic [STATUS_W-1:0]        status,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    localparam int DIM_BITS = $clog2(MAX_DIM);
    localparam int PIX_W    = (PIXEL_BITS < PIXEL_W) ? PIXEL_BITS : PIXEL_W;
    localparam int SUM_W    = PIX_W + 2 * DIM_BITS;
    localparam int MOM_W    = SUM_W + DIM_BITS;
    localparam int ENTRY_W  = 1 + SUM_W + 2 * MOM_W;

    logic [CFG_DIM_W-1:0] width_reg;
    logic [CFG_DIM_W-1:0] height_reg;
    logic [COORD_W-1:0]   ref_x_reg;
    logic [COORD_W-1:0]   ref_y_reg;
    logic                 cfg_clear;

    q_status_t            q_stat;
    logic                 q_push;
    logic                 q_pop;
    logic [ENTRY_W-1:0]   q_wdata;
    logic [ENTRY_W-1:0]   q_rdata;

    // Configuration registers; a size write restarts the frame.
    assign cfg_clear = cfg_we && ((cfg_reg_t'(cfg_index) == REG_FRAME_WIDTH) ||
                                  (cfg_reg_t'(cfg_index) == REG_FRAME_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            ref_x_reg  <= '0;
            ref_y_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  width_reg  <= cfg_data[CFG_DIM_W-1:0];
                REG_FRAME_HEIGHT: height_reg <= cfg_data[CFG_DIM_W-1:0];
                REG_REF_X:        ref_x_reg  <= cfg_data[COORD_W-1:0];
                REG_REF_Y:        ref_y_reg  <= cfg_data[COORD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Front end: pixel intake and moment sums.
    fcg_front #(
        .MAX_DIM    (MAX_DIM),
        .PIXEL_BITS (PIXEL_BITS),
        .SUM_W      (SUM_W),
        .MOM_W      (MOM_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel        (pixel),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .cfg_clear    (cfg_clear),
        .q_stat       (q_stat),
        .q_push       (q_push),
        .q_data       (q_wdata)
    );

    // Finished frame sums waiting for the divider.
    fcg_queue #(
        .DATA_W (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .stat      (q_stat)
    );

    // Back end: division and result register.
    fcg_back #(
        .SUM_W     (SUM_W),
        .MOM_W     (MOM_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .ref_x     (ref_x_reg),
        .ref_y     (ref_y_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .center_x  (center_x),
        .center_y  (center_y),
        .offset_x  (offset_x),
        .offset_y  (offset_y),
        .status    (status)
    );

    // A frame end never arrives at a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_stat.count < QCNT_W'(QUEUE_DEPTH)))
        else $error("frame queue overflow");

    // Input is held off whenever the queue is full.
    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (q_stat.count == QCNT_W'(QUEUE_DEPTH)) |-> in_stall)
        else $error("input accepted with full frame queue");

    // A result without a centroid carries zero fields.
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != STATUS_OK)) |->
            ((center_x == '0) && (center_y == '0) &&
             (offset_x == '0) && (offset_y == '0)))
        else $error("nonzero fields on a failed frame");

    // The queue is only drained when it holds something.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("pop from empty frame queue");

endmodule

// ===== rtl/core/fcg_front.sv =====
module fcg_front
    import fcg_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF,
    parameter int SUM_W      = 40,
    parameter int MOM_W      = 52
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [PIXEL_W-1:0]            pixel,
    input  logic [CFG_DIM_W-1:0]          frame_width,
    input  logic [CFG_DIM_W-1:0]          frame_height,
    input  logic                          cfg_clear,
    input  q_status_t                     q_stat,
    output logic                          q_push,
    output logic [1+SUM_W+2*MOM_W-1:0]    q_data
);

    localparam int DIM_BITS = $clog2(MAX_DIM);
    localparam int PIX_W    = (PIXEL_BITS < PIXEL_W) ? PIXEL_BITS : PIXEL_W;
    localparam int PROD_W   = PIX_W + DIM_BITS;
    localparam int EFF_W    = (DIM_BITS + 1 > CFG_DIM_W) ? DIM_BITS + 1 : CFG_DIM_W;

    logic [EFF_W-1:0]    w_eff;
    logic [EFF_W-1:0]    h_eff;
    logic                small_frame;
    logic                in_accept;
    logic                col_last;
    logic                row_last;
    logic [QCNT_W:0]     need;

    logic [DIM_BITS-1:0] col_reg;
    logic [DIM_BITS-1:0] col_next;
    logic [DIM_BITS-1:0] row_reg;
    logic [DIM_BITS-1:0] row_next;

    logic                s1_valid_reg;
    logic                s1_last_reg;
    logic [PIX_W-1:0]    s1_pix_reg;
    logic [PROD_W-1:0]   s1_px_reg;
    logic [PROD_W-1:0]   s1_py_reg;

    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [MOM_W-1:0]    mx_reg;
    logic [MOM_W-1:0]    mx_next;
    logic [MOM_W-1:0]    my_reg;
    logic [MOM_W-1:0]    my_next;

    // Effective frame size: zero acts as one, oversize clamps to the maximum.
    always_comb
    begin
        if (frame_width == '0)
            w_eff = EFF_W'(1);
        else if (EFF_W'(frame_width) > EFF_W'(MAX_DIM))
            w_eff = EFF_W'(MAX_DIM);
        else
            w_eff = EFF_W'(frame_width);

        if (frame_height == '0)
            h_eff = EFF_W'(1);
        else if (EFF_W'(frame_height) > EFF_W'(MAX_DIM))
            h_eff = EFF_W'(MAX_DIM);
        else
            h_eff = EFF_W'(frame_height);
    end

    assign small_frame = (w_eff < EFF_W'(MIN_DIM)) || (h_eff < EFF_W'(MIN_DIM));

    // Hold off input unless the queue has room for every frame end in flight.
    assign need     = (QCNT_W+1)'(q_stat.count) + (QCNT_W+1)'(s1_valid_reg && s1_last_reg);
    assign in_stall = (need >= (QCNT_W+1)'(QUEUE_DEPTH));
    assign in_accept = in_valid && !in_stall;

    // Raster position of the accepted pixel.
    assign col_last = ((EFF_W'(col_reg) + EFF_W'(1)) >= w_eff);
    assign row_last = ((EFF_W'(row_reg) + EFF_W'(1)) >= h_eff);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_accept)
        begin
            if (col_last)
            begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + DIM_BITS'(1);
            end
            else
            begin
                col_next = col_reg + DIM_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_clear)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Product stage: pixel weighted by column and by row.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (cfg_clear)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= in_accept;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_last_reg <= col_last && row_last;
            s1_pix_reg  <= pixel[PIX_W-1:0];
            s1_px_reg   <= PROD_W'(pixel[PIX_W-1:0]) * PROD_W'(col_reg);
            s1_py_reg   <= PROD_W'(pixel[PIX_W-1:0]) * PROD_W'(row_reg);
        end
    end

    // Accumulate; the last pixel of a frame sends the sums to the queue.
    assign sum_next = sum_reg + SUM_W'(s1_pix_reg);
    assign mx_next  = mx_reg + MOM_W'(s1_px_reg);
    assign my_next  = my_reg + MOM_W'(s1_py_reg);

    assign q_push = s1_valid_reg && s1_last_reg;
    assign q_data = {small_frame, sum_next, mx_next, my_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            mx_reg  <= '0;
            my_reg  <= '0;
        end
        else if (cfg_clear || q_push)
        begin
            sum_reg <= '0;
            mx_reg  <= '0;
            my_reg  <= '0;
        end
        else if (s1_valid_reg)
        begin
            sum_reg <= sum_next;
            mx_reg  <= mx_next;
            my_reg  <= my_next;
        end
    end

endmodule

// ===== rtl/core/fcg_queue.sv =====
module fcg_queue
    import fcg_pkg::*;
#(
    parameter int DATA_W = 145
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output q_status_t         stat
);

    logic [DATA_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_pop;

    assign do_pop     = pop && (count_reg != '0);
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;
    assign pop_data   = entry_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + QPTR_W'(1);
            if (push && !do_pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (do_pop && !push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

endmodule

// ===== rtl/core/fcg_back.sv =====
module fcg_back
    import fcg_pkg::*;
#(
    parameter int SUM_W     = 40,
    parameter int MOM_W     = 52,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  q_status_t                  q_stat,
    input  logic [1+SUM_W+2*MOM_W-1:0] q_data,
    output logic                       q_pop,
    input  logic [COORD_W-1:0]         ref_x,
    input  logic [COORD_W-1:0]         ref_y,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [COORD_W-1:0]         center_x,
    output logic [COORD_W-1:0]         center_y,
    output logic signed [OFFSET_W-1:0] offset_x,
    output logic signed [OFFSET_W-1:0] offset_y,
    output logic [STATUS_W-1:0]        status
);

    localparam int NUM_W = MOM_W + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W);
    localparam int QX_W  = (NUM_W > COORD_W) ? NUM_W : COORD_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_FIN  = 4'b0100,
        ST_DONE = 4'b1000
    } back_state_t;

    back_state_t        state_reg;
    back_state_t        state_next;

    logic               e_small;
    logic [SUM_W-1:0]   e_sum;
    logic [MOM_W-1:0]   e_mx;
    logic [MOM_W-1:0]   e_my;

    logic [SUM_W-1:0]   den_reg;
    logic [NUM_W-1:0]   qx_reg;
    logic [NUM_W-1:0]   qy_reg;
    logic [SUM_W-1:0]   rx_reg;
    logic [SUM_W-1:0]   ry_reg;
    logic [CNT_W-1:0]   cnt_reg;

    logic [SUM_W:0]     tx;
    logic [SUM_W:0]     ty;
    logic               gex;
    logic               gey;
    logic [QX_W-1:0]    qx_ext;
    logic [QX_W-1:0]    qy_ext;
    logic [COORD_W-1:0] cx_sat;
    logic [COORD_W-1:0] cy_sat;

    logic [COORD_W-1:0]         cx_reg;
    logic [COORD_W-1:0]         cy_reg;
    logic signed [OFFSET_W-1:0] ox_reg;
    logic signed [OFFSET_W-1:0] oy_reg;
    logic [STATUS_W-1:0]        status_reg;

    assign {e_small, e_sum, e_mx, e_my} = q_data;

    // One restoring step per cycle on both lanes; quotient bits shift in
    // at the bottom of the numerator register.
    assign tx  = {rx_reg, qx_reg[NUM_W-1]};
    assign ty  = {ry_reg, qy_reg[NUM_W-1]};
    assign gex = (tx >= {1'b0, den_reg});
    assign gey = (ty >= {1'b0, den_reg});

    // Clamp the quotient to the coordinate range.
    assign qx_ext = QX_W'(qx_reg);
    assign qy_ext = QX_W'(qy_reg);
    assign cx_sat = (qx_ext > QX_W'(COORD_MAX)) ? COORD_MAX : qx_ext[COORD_W-1:0];
    assign cy_sat = (qy_ext > QX_W'(COORD_MAX)) ? COORD_MAX : qy_ext[COORD_W-1:0];

    // Sequencer: take a frame, divide unless it is small or its sum is zero, present the result.
    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    q_pop = 1'b1;
                    if (e_small || (e_sum == '0))
                        state_next = ST_DONE;
                    else
                        state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_W'(NUM_W - 1))
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Divider datapath and result registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    den_reg <= e_sum;
                    qx_reg  <= NUM_W'(e_mx) << FRAC_BITS;
                    qy_reg  <= NUM_W'(e_my) << FRAC_BITS;
                    rx_reg  <= '0;
                    ry_reg  <= '0;
                    cnt_reg <= '0;
                    cx_reg  <= '0;
                    cy_reg  <= '0;
                    ox_reg  <= '0;
                    oy_reg  <= '0;
                    if (e_small)
                        status_reg <= STATUS_SMALL;
                    else if (e_sum == '0)
                        status_reg <= STATUS_ZERO;
                    else
                        status_reg <= STATUS_OK;
                end
            end
            ST_DIV:
            begin
                rx_reg  <= gex ? SUM_W'(tx - {1'b0, den_reg}) : tx[SUM_W-1:0];
                ry_reg  <= gey ? SUM_W'(ty - {1'b0, den_reg}) : ty[SUM_W-1:0];
                qx_reg  <= {qx_reg[NUM_W-2:0], gex};
                qy_reg  <= {qy_reg[NUM_W-2:0], gey};
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            ST_FIN:
            begin
                cx_reg <= cx_sat;
                cy_reg <= cy_sat;
                ox_reg <= OFFSET_W'({1'b0, ref_x}) - OFFSET_W'({1'b0, cx_sat});
                oy_reg <= OFFSET_W'({1'b0, ref_y}) - OFFSET_W'({1'b0, cy_sat});
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = (state_reg == ST_DONE);
    assign center_x  = cx_reg;
    assign center_y  = cy_reg;
    assign offset_x  = ox_reg;
    assign offset_y  = oy_reg;
    assign status    = status_reg;

endmodule
